// File: rtl/sldo_pkg.sv
// Package for the slew-limited drive odometry core.
// Holds the controller states, the command and status structs, register indexes,
// fixed-point constants and the CORDIC arctangent table. No dependencies.
`default_nettype none

package sldo_pkg;

    localparam int MAX_SUBSTEPS_DEF      = 16;
    localparam int CORDIC_ITERATIONS_DEF = 16;
    localparam int ATAN_DEPTH            = 24;
    localparam int ITER_IDX_W            = 5;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_ACCEL_LINEAR  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ACCEL_ANGULAR = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DECEL_LINEAR  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DECEL_ANGULAR = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_COMMAND_TICKS = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_TICK_PERIOD   = 3'd5;

    localparam logic [15:0] TICK_PERIOD_RESET = 16'd1311;

    localparam int CORDIC_W = 34;
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic [29:0] RAD_TO_BAM = 30'd683565276;
    localparam logic [32:0] QUARTER_M_MINUS1 = 33'd4194303;

    localparam int TURN_W   = 62;
    localparam int DIVIDEND_W = 61;

    localparam logic [31:0] ATAN_TABLE [ATAN_DEPTH] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
    };

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_DIV_S,
        S_DIV_S_WAIT,
        S_DIV_T,
        S_DIV_T_WAIT,
        S_SUB_INIT,
        S_CORDIC,
        S_MUL_X,
        S_ACC_X,
        S_ACC_Y,
        S_DONE
    } t_state;

    typedef struct packed {
        logic                  load_cmd;
        logic                  do_slew;
        logic                  mul_v;
        logic                  mul_turn;
        logic                  div_start;
        logic                  div_sel;
        logic                  take_d;
        logic                  take_dh;
        logic                  cordic_init;
        logic                  cordic_step;
        logic [ITER_IDX_W-1:0] iter;
        logic                  mul_en;
        logic                  mul_sel;
        logic                  acc_x;
        logic                  acc_y;
        logic                  out_load;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic last_sub;
    } t_status;

endpackage

`default_nettype wire

// File: rtl/sldo_div.sv
// Iterative restoring divider for unsigned operands, one quotient bit per cycle.
// Used by the datapath for the substep distance and heading increment; no dependencies.
`default_nettype none

module sldo_div #(
    parameter int DW = 61,
    parameter int VW = 5
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [DW-1:0] i_dividend,
    input  wire logic [VW-1:0] i_divisor,
    output logic               o_done,
    output logic [DW-1:0]      o_quotient
);

    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] r_quo;
    logic [VW-1:0] r_rem;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [VW:0]   w_trial;
    logic [VW:0]   w_diff;
    logic          w_bit;

    assign w_trial = {r_rem, r_quo[DW-1]};
    assign w_diff  = w_trial - {1'b0, i_divisor};
    assign w_bit   = (w_trial >= {1'b0, i_divisor});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_quo <= {r_quo[DW-2:0], w_bit};
            r_rem <= w_bit ? w_diff[VW-1:0] : w_trial[VW-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

// File: rtl/sldo_datapath.sv
// Datapath: configuration registers, motion state, multiplier, CORDIC and pose update.
// Depends on sldo_pkg and sldo_div; driven by commands from sldo_ctrl.
`default_nettype none

module sldo_datapath #(
    parameter int MAX_SUBSTEPS = sldo_pkg::MAX_SUBSTEPS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire sldo_pkg::t_cmd                     i_cmd,
    output sldo_pkg::t_status                       o_sts,
    input  wire logic                               i_cfg_we,
    input  wire logic [sldo_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  wire logic [sldo_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire logic signed [15:0]                 i_target_linear,
    input  wire logic signed [15:0]                 i_target_angular,
    output logic signed [31:0]                      o_pos_x,
    output logic signed [31:0]                      o_pos_y,
    output logic [15:0]                             o_heading,
    output logic signed [15:0]                      o_linear_speed,
    output logic signed [15:0]                      o_angular_speed,
    output logic                                    o_cmd_alive
);

    localparam int NW = $clog2(MAX_SUBSTEPS + 1);
    localparam int CW = sldo_pkg::CORDIC_W;
    localparam int TW = sldo_pkg::TURN_W;
    localparam int DV = sldo_pkg::DIVIDEND_W;

    logic [14:0] r_accel_lin, r_accel_ang, r_decel_lin, r_decel_ang;
    logic [15:0] r_cmd_ticks, r_period;

    logic signed [31:0] r_x, r_y;
    logic [15:0]        r_head;
    logic signed [15:0] r_vlin, r_vang, r_glin, r_gang;
    logic [15:0]        r_ticks;
    logic               r_active;

    logic signed [31:0]    r_s, r_wdt, r_d;
    logic signed [TW-1:0]  r_turn;
    logic [NW-1:0]         r_n, r_k;
    logic [15:0]           r_dh;
    logic signed [CW-1:0]  r_cx, r_cy;
    logic [31:0]           r_cz;
    logic signed [65:0]    r_prod;

    logic signed [32:0] w_s_full;
    logic signed [32:0] w_wdt_full;
    logic signed [62:0] w_turn_full;
    logic [31:0]        w_mag_s;
    logic [DV-1:0]      w_mag_t;
    logic [32:0]        w_nsum;
    logic [10:0]        w_nraw;
    logic [NW-1:0]      w_n;
    logic [DV-1:0]      w_dividend;
    logic               w_div_done;
    logic [DV-1:0]      w_quot;
    logic [31:0]        w_q32;
    logic [TW-1:0]      w_qt, w_qt_rnd;
    logic [31:0]        w_z0, w_zq;
    logic signed [CW-1:0] w_shx, w_shy;
    logic [31:0]        w_atan;
    logic signed [CW-1:0] w_mul_b;
    logic signed [65:0] w_rnd;
    logic signed [27:0] w_inc;
    logic signed [32:0] w_sum;
    logic signed [31:0] w_sat;
    logic signed [31:0] w_acc_base;

    function automatic logic signed [15:0] slew(input logic signed [15:0] cur,
                                                input logic signed [15:0] tgt,
                                                input logic [14:0] lim);
        logic signed [16:0] diff;
        logic signed [16:0] lim17;
        logic signed [16:0] res;
        diff  = {tgt[15], tgt} - {cur[15], cur};
        lim17 = {2'b00, lim};
        if (diff > lim17) begin
            diff = lim17;
        end
        if (diff < -lim17) begin
            diff = -lim17;
        end
        res = {cur[15], cur} + diff;
        return res[15:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel_lin <= '0;
            r_accel_ang <= '0;
            r_decel_lin <= '0;
            r_decel_ang <= '0;
            r_cmd_ticks <= '0;
            r_period    <= sldo_pkg::TICK_PERIOD_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sldo_pkg::REG_ACCEL_LINEAR:  r_accel_lin <= i_cfg_data[14:0];
                sldo_pkg::REG_ACCEL_ANGULAR: r_accel_ang <= i_cfg_data[14:0];
                sldo_pkg::REG_DECEL_LINEAR:  r_decel_lin <= i_cfg_data[14:0];
                sldo_pkg::REG_DECEL_ANGULAR: r_decel_ang <= i_cfg_data[14:0];
                sldo_pkg::REG_COMMAND_TICKS: r_cmd_ticks <= i_cfg_data;
                sldo_pkg::REG_TICK_PERIOD:   r_period    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_s_full    = r_vlin * $signed({1'b0, r_period});
    assign w_wdt_full  = r_vang * $signed({1'b0, r_period});
    assign w_turn_full = r_wdt * $signed({1'b0, sldo_pkg::RAD_TO_BAM});
    assign w_mag_s     = r_s[31] ? (~r_s + 32'd1) : r_s;
    assign w_mag_t     = r_turn[TW-1] ? DV'(~r_turn + TW'(1)) : r_turn[DV-1:0];
    assign w_nsum      = {1'b0, w_mag_s} + sldo_pkg::QUARTER_M_MINUS1;
    assign w_nraw      = w_nsum[32:22];

    always_comb begin
        if (w_nraw == 11'd0) begin
            w_n = NW'(1);
        end else if (w_nraw > 11'(MAX_SUBSTEPS)) begin
            w_n = NW'(MAX_SUBSTEPS);
        end else begin
            w_n = w_nraw[NW-1:0];
        end
    end

    assign w_dividend = i_cmd.div_sel ? w_mag_t : DV'(w_mag_s);

    sldo_div #(
        .DW(DV),
        .VW(NW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dividend),
        .i_divisor  (r_n),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    assign w_q32    = w_quot[31:0];
    assign w_qt     = r_turn[TW-1] ? (~{1'b0, w_quot} + TW'(1)) : {1'b0, w_quot};
    assign w_qt_rnd = w_qt + (TW'(1) << 43);

    assign w_z0   = {r_head, 16'h0000};
    assign w_zq   = w_z0 + 32'h4000_0000;
    assign w_shx  = r_cx >>> i_cmd.iter;
    assign w_shy  = r_cy >>> i_cmd.iter;
    assign w_atan = sldo_pkg::ATAN_TABLE[i_cmd.iter];

    assign w_mul_b    = i_cmd.mul_sel ? r_cy : r_cx;
    assign w_rnd      = r_prod + (66'sd1 <<< 37);
    assign w_inc      = w_rnd[65:38];
    assign w_acc_base = i_cmd.acc_y ? r_y : r_x;
    assign w_sum      = {w_acc_base[31], w_acc_base} + {{5{w_inc[27]}}, w_inc};

    always_comb begin
        if (w_sum[32] != w_sum[31]) begin
            w_sat = w_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            w_sat = w_sum[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x      <= '0;
            r_y      <= '0;
            r_head   <= '0;
            r_vlin   <= '0;
            r_vang   <= '0;
            r_glin   <= '0;
            r_gang   <= '0;
            r_ticks  <= '0;
            r_active <= 1'b0;
        end else begin
            if (i_cmd.load_cmd) begin
                r_glin   <= i_target_linear;
                r_gang   <= i_target_angular;
                r_ticks  <= r_cmd_ticks;
                r_active <= (r_cmd_ticks != 16'd0);
            end
            if (i_cmd.do_slew) begin
                r_active <= (r_ticks != 16'd0);
                if (r_ticks != 16'd0) begin
                    r_ticks <= r_ticks - 16'd1;
                    r_vlin  <= slew(r_vlin, r_glin, r_accel_lin);
                    r_vang  <= slew(r_vang, r_gang, r_accel_ang);
                end else begin
                    r_vlin <= slew(r_vlin, 16'sd0, r_decel_lin);
                    r_vang <= slew(r_vang, 16'sd0, r_decel_ang);
                end
            end
            if (i_cmd.acc_x) begin
                r_x <= w_sat;
            end
            if (i_cmd.acc_y) begin
                r_y    <= w_sat;
                r_head <= r_head + r_dh;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_v) begin
            r_s   <= w_s_full[31:0];
            r_wdt <= w_wdt_full[31:0];
        end
        if (i_cmd.mul_turn) begin
            r_turn <= w_turn_full[TW-1:0];
            r_n    <= w_n;
        end
        if (i_cmd.take_d) begin
            r_d <= r_s[31] ? (~w_q32 + 32'd1) : w_q32;
        end
        if (i_cmd.take_dh) begin
            r_dh <= w_qt_rnd[59:44];
            r_k  <= '0;
        end
        if (i_cmd.cordic_init) begin
            r_cy <= '0;
            if (w_zq[31]) begin
                r_cx <= -sldo_pkg::CORDIC_GAIN;
                r_cz <= w_z0 ^ 32'h8000_0000;
            end else begin
                r_cx <= sldo_pkg::CORDIC_GAIN;
                r_cz <= w_z0;
            end
        end else if (i_cmd.cordic_step) begin
            if (r_cz[31]) begin
                r_cx <= r_cx + w_shy;
                r_cy <= r_cy - w_shx;
                r_cz <= r_cz + w_atan;
            end else begin
                r_cx <= r_cx - w_shy;
                r_cy <= r_cy + w_shx;
                r_cz <= r_cz - w_atan;
            end
        end
        if (i_cmd.mul_en) begin
            r_prod <= r_d * w_mul_b;
        end
        if (i_cmd.acc_y) begin
            r_k <= r_k + 1'b1;
        end
        if (i_cmd.out_load) begin
            o_pos_x         <= r_x;
            o_pos_y         <= r_y;
            o_heading       <= r_head;
            o_linear_speed  <= r_vlin;
            o_angular_speed <= r_vang;
            o_cmd_alive     <= r_active;
        end
    end

    assign o_sts.div_done = w_div_done;
    assign o_sts.last_sub = (r_k == (r_n - 1'b1));

    a_sub_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.acc_y |-> (r_k < r_n))
        else $error("substep counter ran past the substep count");

    a_n_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.mul_turn |=> (r_n != '0) && (r_n <= NW'(MAX_SUBSTEPS)))
        else $error("substep count out of range");

    a_cmd_reload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_cmd |=> (r_ticks == $past(r_cmd_ticks)))
        else $error("command did not reload the timeout counter");

endmodule

`default_nettype wire

// File: rtl/sldo_ctrl.sv
// Controller state machine: sequences the tick computation and owns the input and result handshakes.
// Depends on sldo_pkg; drives sldo_datapath through the command struct.
`default_nettype none

module sldo_ctrl #(
    parameter int CORDIC_ITERATIONS = sldo_pkg::CORDIC_ITERATIONS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic              i_action,
    output logic                   o_valid,
    input  wire logic              i_ready,
    input  wire sldo_pkg::t_status i_sts,
    output sldo_pkg::t_cmd         o_cmd
);

    localparam int IW = $clog2(CORDIC_ITERATIONS);

    sldo_pkg::t_state r_state, n_state;
    logic [IW-1:0]    r_iter, n_iter;
    logic             r_out_valid, n_out_valid;
    logic             w_out_free;

    assign w_out_free = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sldo_pkg::S_IDLE;
            r_iter      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_iter      <= n_iter;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_iter      = r_iter;
        n_out_valid = r_out_valid && !i_ready;
        o_cmd       = '0;
        o_cmd.iter  = sldo_pkg::ITER_IDX_W'(r_iter);
        o_ready     = 1'b0;
        case (r_state)
            sldo_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    if (i_action) begin
                        o_cmd.do_slew = 1'b1;
                        n_state = sldo_pkg::S_MUL1;
                    end else begin
                        o_cmd.load_cmd = 1'b1;
                        n_state = sldo_pkg::S_DONE;
                    end
                end
            end
            sldo_pkg::S_MUL1: begin
                o_cmd.mul_v = 1'b1;
                n_state = sldo_pkg::S_MUL2;
            end
            sldo_pkg::S_MUL2: begin
                o_cmd.mul_turn = 1'b1;
                n_state = sldo_pkg::S_DIV_S;
            end
            sldo_pkg::S_DIV_S: begin
                o_cmd.div_start = 1'b1;
                n_state = sldo_pkg::S_DIV_S_WAIT;
            end
            sldo_pkg::S_DIV_S_WAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.take_d = 1'b1;
                    n_state = sldo_pkg::S_DIV_T;
                end
            end
            sldo_pkg::S_DIV_T: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = 1'b1;
                n_state = sldo_pkg::S_DIV_T_WAIT;
            end
            sldo_pkg::S_DIV_T_WAIT: begin
                o_cmd.div_sel = 1'b1;
                if (i_sts.div_done) begin
                    o_cmd.take_dh = 1'b1;
                    n_state = sldo_pkg::S_SUB_INIT;
                end
            end
            sldo_pkg::S_SUB_INIT: begin
                o_cmd.cordic_init = 1'b1;
                n_iter  = '0;
                n_state = sldo_pkg::S_CORDIC;
            end
            sldo_pkg::S_CORDIC: begin
                o_cmd.cordic_step = 1'b1;
                n_iter = r_iter + 1'b1;
                if (r_iter == IW'(CORDIC_ITERATIONS - 1)) begin
                    n_state = sldo_pkg::S_MUL_X;
                end
            end
            sldo_pkg::S_MUL_X: begin
                o_cmd.mul_en = 1'b1;
                n_state = sldo_pkg::S_ACC_X;
            end
            sldo_pkg::S_ACC_X: begin
                o_cmd.acc_x   = 1'b1;
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = 1'b1;
                n_state = sldo_pkg::S_ACC_Y;
            end
            sldo_pkg::S_ACC_Y: begin
                o_cmd.acc_y = 1'b1;
                n_state = i_sts.last_sub ? sldo_pkg::S_DONE : sldo_pkg::S_SUB_INIT;
            end
            sldo_pkg::S_DONE: begin
                if (w_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid = 1'b1;
                    n_state = sldo_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sldo_pkg::S_IDLE;
            end
        endcase
    end

    assign o_valid = r_out_valid;

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state != sldo_pkg::S_IDLE))
        else $error("accepted transaction did not start work");

    a_done_raises_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sldo_pkg::S_DONE && w_out_free) |=> r_out_valid)
        else $error("finished result was not presented");

    a_div_to_substep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sldo_pkg::S_DIV_T_WAIT && i_sts.div_done)
            |=> (r_state == sldo_pkg::S_SUB_INIT))
        else $error("substeps did not follow the heading division");

endmodule

`default_nettype wire

// File: rtl/slew_limited_drive_odometry_core.sv
// Slew-limited drive odometry: a velocity command or a tick in, one pose result out.
// A command loads the new targets and then presents its result. A tick runs two passes of
// the bit-serial divider, then one CORDIC rotation per substep for n substeps, where n is
// the substep count (1 to MAX_SUBSTEPS). One transaction is in work at a time; a finished
// result waits in the output register while the next transaction is taken. Configuration
// writes are always taken and must only be issued while the block is idle.
// Depends on sldo_pkg, sldo_ctrl and sldo_datapath.
`default_nettype none

module slew_limited_drive_odometry_core #(
    parameter int MAX_SUBSTEPS      = sldo_pkg::MAX_SUBSTEPS_DEF,
    parameter int CORDIC_ITERATIONS = sldo_pkg::CORDIC_ITERATIONS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [sldo_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [sldo_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                             i_valid,
    output logic                                  o_ready,
    input  wire logic                             i_action,
    input  wire logic signed [15:0]               i_target_linear,
    input  wire logic signed [15:0]               i_target_angular,
    output logic                                  o_valid,
    input  wire logic                             i_ready,
    output logic signed [31:0]                    o_pos_x,
    output logic signed [31:0]                    o_pos_y,
    output logic [15:0]                           o_heading,
    output logic signed [15:0]                    o_linear_speed,
    output logic signed [15:0]                    o_angular_speed,
    output logic                                  o_cmd_alive
);

    sldo_pkg::t_cmd    w_cmd;
    sldo_pkg::t_status w_sts;

    assign o_cfg_ready = 1'b1;

    sldo_ctrl #(
        .CORDIC_ITERATIONS(CORDIC_ITERATIONS)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_action (i_action),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .i_sts    (w_sts),
        .o_cmd    (w_cmd)
    );

    sldo_datapath #(
        .MAX_SUBSTEPS (MAX_SUBSTEPS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_cfg_we         (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_target_linear  (i_target_linear),
        .i_target_angular (i_target_angular),
        .o_pos_x          (o_pos_x),
        .o_pos_y          (o_pos_y),
        .o_heading        (o_heading),
        .o_linear_speed   (o_linear_speed),
        .o_angular_speed  (o_angular_speed),
        .o_cmd_alive      (o_cmd_alive)
    );

endmodule

`default_nettype wire

// File: bench/sldo_checker.sv
// Checker for the slew-limited drive odometry core: watches the configuration, command
// and result channels, predicts each pose result and compares it field by field.
// Depends on sldo_pkg for register indexes and the arctangent table.
`default_nettype none

module sldo_checker (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_valid,
    input  wire logic                             i_cfg_ready,
    input  wire logic [sldo_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [sldo_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                             i_in_valid,
    input  wire logic                             i_in_ready,
    input  wire logic                             i_action,
    input  wire logic signed [15:0]               i_target_linear,
    input  wire logic signed [15:0]               i_target_angular,
    input  wire logic                             i_out_valid,
    input  wire logic                             i_out_ready,
    input  wire logic signed [31:0]               i_pos_x,
    input  wire logic signed [31:0]               i_pos_y,
    input  wire logic [15:0]                      i_heading,
    input  wire logic signed [15:0]               i_linear_speed,
    input  wire logic signed [15:0]               i_angular_speed,
    input  wire logic                             i_cmd_alive,
    output int                                    o_failures,
    output int                                    o_pending
);

    localparam logic ACT_COMMAND = 1'b0;
    localparam int   SUBSTEP_MAX = 16;
    localparam int   ROTATE_ITER = 16;
    localparam longint GAIN_Q30   = 64'sd652032874;
    localparam longint BAM_SCALE  = 64'sd683565276;
    localparam longint QUARTER_M  = 64'sd4194304;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [15:0]        heading;
        logic signed [15:0] linear_speed;
        logic signed [15:0] angular_speed;
        logic               cmd_alive;
    } t_pose;

    logic [14:0] accel_lin, accel_ang, decel_lin, decel_ang;
    logic [15:0] active_ticks, period;
    int          x_pos, y_pos, lin_v, ang_v, goal_lin, goal_ang;
    logic [15:0] hdg;
    int unsigned ticks_left;
    t_pose       pose_queue[$];

    assign o_pending = pose_queue.size();

    function automatic int slew_to(int cur, int tgt, int lim);
        int diff;
        diff = tgt - cur;
        if (diff > lim) diff = lim;
        if (diff < -lim) diff = -lim;
        return cur + diff;
    endfunction

    function automatic int sat32(longint v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return int'(v);
    endfunction

    task automatic rotate(input logic [31:0] ang, output longint c, output longint s);
        longint      cx, cy, nx, ny;
        logic [31:0] z, quad;
        cx = GAIN_Q30;
        cy = 0;
        z = ang;
        quad = z + 32'h4000_0000;
        if (quad[31]) begin
            cx = -GAIN_Q30;
            z = z + 32'h8000_0000;
        end
        for (int i = 0; i < ROTATE_ITER; i++) begin
            if (z[31]) begin
                nx = cx + (cy >>> i);
                ny = cy - (cx >>> i);
                z = z + sldo_pkg::ATAN_TABLE[i];
            end else begin
                nx = cx - (cy >>> i);
                ny = cy + (cx >>> i);
                z = z - sldo_pkg::ATAN_TABLE[i];
            end
            cx = nx;
            cy = ny;
        end
        c = cx;
        s = cy;
    endtask

    task automatic advance_pose();
        longint travel, turn, mag, n, d, dh, c, s;
        travel = longint'(lin_v) * longint'(period);
        turn = longint'(ang_v) * longint'(period) * BAM_SCALE;
        mag = travel < 0 ? -travel : travel;
        n = (mag + QUARTER_M - 1) / QUARTER_M;
        if (n < 1) n = 1;
        if (n > SUBSTEP_MAX) n = SUBSTEP_MAX;
        d = travel / n;
        dh = (turn / n + (64'sd1 <<< 43)) >>> 44;
        for (longint k = 0; k < n; k++) begin
            rotate({hdg, 16'h0000}, c, s);
            x_pos = sat32(longint'(x_pos) + ((d * c + (64'sd1 <<< 37)) >>> 38));
            y_pos = sat32(longint'(y_pos) + ((d * s + (64'sd1 <<< 37)) >>> 38));
            hdg = hdg + dh[15:0];
        end
    endtask

    task automatic predict_pose(input logic act, input logic signed [15:0] tl,
                                input logic signed [15:0] ta);
        t_pose p;
        logic  active;
        if (act == ACT_COMMAND) begin
            goal_lin = tl;
            goal_ang = ta;
            ticks_left = active_ticks;
            active = ticks_left != 0;
        end else begin
            active = ticks_left != 0;
            if (active) begin
                ticks_left--;
                lin_v = slew_to(lin_v, goal_lin, int'(accel_lin));
                ang_v = slew_to(ang_v, goal_ang, int'(accel_ang));
            end else begin
                lin_v = slew_to(lin_v, 0, int'(decel_lin));
                ang_v = slew_to(ang_v, 0, int'(decel_ang));
            end
            advance_pose();
        end
        p.pos_x = x_pos;
        p.pos_y = y_pos;
        p.heading = hdg;
        p.linear_speed = lin_v[15:0];
        p.angular_speed = ang_v[15:0];
        p.cmd_alive = active;
        pose_queue.push_back(p);
    endtask

    task automatic report(input string what, input longint want, input longint got);
        $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, want, got);
        o_failures++;
    endtask

    initial o_failures = 0;

    always @(posedge i_clk) begin
        t_pose p;
        if (!i_rst_n) begin
            accel_lin <= '0;
            accel_ang <= '0;
            decel_lin <= '0;
            decel_ang <= '0;
            active_ticks <= '0;
            period <= sldo_pkg::TICK_PERIOD_RESET;
            x_pos = 0;
            y_pos = 0;
            hdg = '0;
            lin_v = 0;
            ang_v = 0;
            goal_lin = 0;
            goal_ang = 0;
            ticks_left = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (pose_queue.size() == 0) begin
                    report("result transactions pending", 0, 1);
                end else begin
                    p = pose_queue.pop_front();
                    if (i_pos_x !== p.pos_x) report("pos_x", p.pos_x, i_pos_x);
                    if (i_pos_y !== p.pos_y) report("pos_y", p.pos_y, i_pos_y);
                    if (i_heading !== p.heading) report("heading", p.heading, i_heading);
                    if (i_linear_speed !== p.linear_speed)
                        report("linear_speed", p.linear_speed, i_linear_speed);
                    if (i_angular_speed !== p.angular_speed)
                        report("angular_speed", p.angular_speed, i_angular_speed);
                    if (i_cmd_alive !== p.cmd_alive)
                        report("cmd_alive", p.cmd_alive, i_cmd_alive);
                end
            end
            if (i_in_valid && i_in_ready)
                predict_pose(i_action, i_target_linear, i_target_angular);
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    sldo_pkg::REG_ACCEL_LINEAR:  accel_lin <= i_cfg_data[14:0];
                    sldo_pkg::REG_ACCEL_ANGULAR: accel_ang <= i_cfg_data[14:0];
                    sldo_pkg::REG_DECEL_LINEAR:  decel_lin <= i_cfg_data[14:0];
                    sldo_pkg::REG_DECEL_ANGULAR: decel_ang <= i_cfg_data[14:0];
                    sldo_pkg::REG_COMMAND_TICKS: active_ticks <= i_cfg_data;
                    sldo_pkg::REG_TICK_PERIOD:   period <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

`default_nettype wire

// File: bench/slew_limited_drive_odometry_core_tb.sv
// Testbench top for the slew-limited drive odometry core: drives configuration writes,
// velocity commands and ticks with random idling, and gives the verdict.
// Depends on sldo_pkg, the core and sldo_checker.
`default_nettype none

module slew_limited_drive_odometry_core_tb;

    localparam logic ACT_COMMAND = 1'b0;
    localparam logic ACT_TICK    = 1'b1;
    localparam logic [sldo_pkg::CFG_INDEX_W-1:0] REG_SPARE_LOW  = 3'd6;
    localparam logic [sldo_pkg::CFG_INDEX_W-1:0] REG_SPARE_HIGH = 3'd7;
    localparam int STALL_LIMIT = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic [sldo_pkg::CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [sldo_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic i_valid = 1'b0;
    logic i_action = 1'b0;
    logic signed [15:0] i_target_linear = '0;
    logic signed [15:0] i_target_angular = '0;
    logic i_ready = 1'b0;
    logic o_cfg_ready, o_ready, o_valid, o_cmd_alive;
    logic signed [31:0] o_pos_x, o_pos_y;
    logic [15:0] o_heading;
    logic signed [15:0] o_linear_speed, o_angular_speed;
    int failures, pending;
    int send_idle = 0;
    int recv_idle = 0;
    int quiet_cycles = 0;

    always #5 i_clk = ~i_clk;

    slew_limited_drive_odometry_core u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_ready(o_ready), .i_action(i_action),
        .i_target_linear(i_target_linear), .i_target_angular(i_target_angular),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_pos_x(o_pos_x), .o_pos_y(o_pos_y), .o_heading(o_heading),
        .o_linear_speed(o_linear_speed), .o_angular_speed(o_angular_speed),
        .o_cmd_alive(o_cmd_alive)
    );

    sldo_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_valid), .i_in_ready(o_ready), .i_action(i_action),
        .i_target_linear(i_target_linear), .i_target_angular(i_target_angular),
        .i_out_valid(o_valid), .i_out_ready(i_ready),
        .i_pos_x(o_pos_x), .i_pos_y(o_pos_y), .i_heading(o_heading),
        .i_linear_speed(o_linear_speed), .i_angular_speed(o_angular_speed),
        .i_cmd_alive(o_cmd_alive),
        .o_failures(failures), .o_pending(pending)
    );

    always @(negedge i_clk) i_ready <= ($urandom_range(99) >= recv_idle);

    // Any accepted transaction on any channel counts as progress.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic cfg_write(input logic [sldo_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [15:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic send(input logic act, input logic [15:0] tl, input logic [15:0] ta);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle) @(negedge i_clk);
        i_valid = 1'b1;
        i_action = act;
        i_target_linear = tl;
        i_target_angular = ta;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    task automatic drain();
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    function automatic logic [15:0] pick_step();
        case ($urandom_range(3))
            0: return 16'd0;
            1: return 16'h7FFF;
            2: return 16'($urandom_range(600));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_target();
        if ($urandom_range(1)) return 16'($urandom);
        return 16'($urandom_range(2047)) - 16'd1024;
    endfunction

    task automatic random_setup();
        cfg_write(sldo_pkg::REG_ACCEL_LINEAR, pick_step());
        cfg_write(sldo_pkg::REG_ACCEL_ANGULAR, pick_step());
        cfg_write(sldo_pkg::REG_DECEL_LINEAR, pick_step());
        cfg_write(sldo_pkg::REG_DECEL_ANGULAR, pick_step());
        case ($urandom_range(3))
            0: cfg_write(sldo_pkg::REG_COMMAND_TICKS, 16'd0);
            1: cfg_write(sldo_pkg::REG_COMMAND_TICKS, 16'hFFFF);
            default: cfg_write(sldo_pkg::REG_COMMAND_TICKS, 16'($urandom_range(1, 20)));
        endcase
        case ($urandom_range(4))
            0: cfg_write(sldo_pkg::REG_TICK_PERIOD, 16'd1);
            1: cfg_write(sldo_pkg::REG_TICK_PERIOD, 16'hFFFF);
            2: cfg_write(sldo_pkg::REG_TICK_PERIOD, 16'($urandom));
            default: cfg_write(sldo_pkg::REG_TICK_PERIOD, 16'($urandom_range(500, 6000)));
        endcase
    endtask

    task automatic random_items(input int count);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < 30)
                send(ACT_COMMAND, pick_target(), pick_target());
            else
                send(ACT_TICK, 16'($urandom), 16'($urandom));
        end
    endtask

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        send_idle = 17;
        recv_idle = 67;
        cfg_write(sldo_pkg::REG_ACCEL_LINEAR, 16'hFFFF);
        cfg_write(sldo_pkg::REG_ACCEL_ANGULAR, 16'h7FFF);
        cfg_write(sldo_pkg::REG_DECEL_LINEAR, 16'h7FFF);
        cfg_write(sldo_pkg::REG_DECEL_ANGULAR, 16'hFFFF);
        cfg_write(sldo_pkg::REG_COMMAND_TICKS, 16'd3);
        cfg_write(sldo_pkg::REG_TICK_PERIOD, 16'hFFFF);
        cfg_write(REG_SPARE_LOW, 16'hFFFF);
        cfg_write(REG_SPARE_HIGH, 16'h1234);
        send(ACT_TICK, 16'h0000, 16'h0000);
        send(ACT_COMMAND, 16'h7FFF, 16'h7FFF);
        repeat (4) send(ACT_TICK, 16'hFFFF, 16'hFFFF);
        send(ACT_COMMAND, 16'h8000, 16'h8000);
        repeat (3) send(ACT_TICK, 16'h5A5A, 16'hA5A5);
        send(ACT_COMMAND, 16'h0000, 16'h0000);
        send(ACT_TICK, 16'h0000, 16'h0000);
        drain();
        cfg_write(sldo_pkg::REG_COMMAND_TICKS, 16'd0);
        cfg_write(sldo_pkg::REG_TICK_PERIOD, 16'd0);
        send(ACT_COMMAND, 16'h7FFF, 16'h8000);
        send(ACT_TICK, 16'h0000, 16'h0000);
        drain();
        cfg_write(sldo_pkg::REG_COMMAND_TICKS, 16'hFFFF);
        cfg_write(sldo_pkg::REG_TICK_PERIOD, 16'd1);
        send(ACT_COMMAND, 16'h8000, 16'h7FFF);
        repeat (3) send(ACT_TICK, 16'h0000, 16'h0000);
        drain();

        for (int phase = 0; phase < 3; phase++) begin
            send_idle = phase == 0 ? 17 : (phase == 1 ? 67 : 0);
            recv_idle = phase == 0 ? 67 : (phase == 1 ? 17 : 0);
            for (int blk = 0; blk < 3; blk++) begin
                random_setup();
                random_items(75);
                drain();
            end
        end

        repeat (20) @(negedge i_clk);
        if (failures == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
rtl/sldo_pkg.sv
rtl/sldo_div.sv
rtl/sldo_datapath.sv
rtl/sldo_ctrl.sv
rtl/slew_limited_drive_odometry_core.sv
bench/sldo_checker.sv
bench/slew_limited_drive_odometry_core_tb.sv
